/* design/nrt_pkg.sv */
// Shared types, constants and a helper of the neighbour signal-strength table.
package nrt_pkg;

   localparam int NRT_ENTRIES = 16;
   localparam int ID_W = 32;
   localparam int RSSI_W = 8;
   localparam int TIME_W = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_DATA_W-1:0] OWN_ID_RESET = '0;
   localparam logic [CSR_DATA_W-1:0] STALE_LIMIT_RESET = 32'd3000;
   localparam logic signed [RSSI_W-1:0] UNKNOWN_RSSI = -8'sd127;

   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ID = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STALE_LIMIT = 1'b1;

   typedef enum logic [2:0] {
      STATUS_UPDATED  = 3'd0,
      STATUS_INSERTED = 3'd1,
      STATUS_IGNORED  = 3'd2,
      STATUS_FULL     = 3'd3,
      STATUS_HIT      = 3'd4,
      STATUS_MISS     = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ID_W-1:0]          peer_id;
      logic signed [RSSI_W-1:0] rssi;
      logic [TIME_W-1:0]        seen_ms;
   } entry_type;

   function automatic logic has_zero_byte(input logic [ID_W-1:0] v);
      return (v[7:0] == 8'd0) || (v[15:8] == 8'd0) ||
             (v[23:16] == 8'd0) || (v[31:24] == 8'd0);
   endfunction

endpackage

/* design/nrt_ifs.sv */
// Request and response channel interfaces of the neighbour signal-strength table.
interface nrt_req_if;
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [31:0]          peer_id;
   logic signed [7:0]    sample_rssi;
   logic [31:0]          now_ms;

   modport source (output valid, output mode, output peer_id, output sample_rssi,
                   output now_ms, input ready);
   modport sink (input valid, input mode, input peer_id, input sample_rssi,
                 input now_ms, output ready);
endinterface

interface nrt_rsp_if;
   logic                  valid;
   logic                  ready;
   nrt_pkg::status_type   status;
   logic signed [7:0]     rssi_value;

   modport source (output valid, output status, output rssi_value, input ready);
   modport sink (input valid, input status, input rssi_value, output ready);
endinterface

/* design/neighbor_rssi_table.sv */
// An empty table skips the scan; otherwise the entry memory is scanned, one memory read per
// entry, until a match at entry k or, when the peer is absent, through all used entries.
// A new item is accepted only once the previous one is finished (ready only while idle),
// and an item also waits while the previous result has not been taken.
// Reset clears the entry count, the registers to their defaults and the control state;
// the entry memory itself is not cleared, as only counted entries are ever read.
module neighbor_rssi_table #(
   parameter int ENTRIES = nrt_pkg::NRT_ENTRIES
) (
   input  logic                                clock,
   input  logic                                reset,
   nrt_req_if.sink                             req_chan,
   nrt_rsp_if.source                           rsp_chan,
   input  logic                                csr_write_en,
   input  logic [nrt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [nrt_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import nrt_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] ENTRIES_C = CW'(ENTRIES);

   entry_type mem [ENTRIES];

   state_type state_ff, state_in;

   logic                     mode_ff;
   logic [ID_W-1:0]          id_ff;
   logic signed [RSSI_W-1:0] sample_ff;
   logic [TIME_W-1:0]        now_ff;

   logic [CW-1:0]            used_ff, used_in;
   logic [CW-1:0]            issue_ff, issue_in;
   logic                     rd_valid_ff, rd_valid_in;
   logic [IW-1:0]            rd_slot_ff;
   entry_type                rd_data_ff;

   logic                     found_ff, found_in;
   logic [IW-1:0]            slot_ff, slot_in;
   logic signed [RSSI_W-1:0] old_rssi_ff, old_rssi_in;
   logic [TIME_W-1:0]        old_seen_ff, old_seen_in;

   logic [CSR_DATA_W-1:0]    own_id_ff;
   logic [CSR_DATA_W-1:0]    stale_limit_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [RSSI_W-1:0] rsp_rssi_ff, rsp_rssi_in;

   logic                     accept;
   logic                     issue;
   logic                     match;
   logic                     last;
   logic [CW-1:0]            slot_next;
   logic                     load_rsp;
   logic                     wr_en;
   logic [IW-1:0]            wr_addr;
   entry_type                wr_data;
   logic signed [9:0]        sum;
   logic signed [9:0]        quot;
   logic [TIME_W-1:0]        age;
   logic                     ignored;

   assign accept = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE);

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.status = rsp_status_ff;
   assign rsp_chan.rssi_value = rsp_rssi_ff;

   // Reads run one ahead of the compare, so one entry is checked every cycle.
   assign issue = (state_ff == ST_SCAN) && (issue_ff < used_ff);
   assign match = rd_valid_ff && (rd_data_ff.peer_id == id_ff);
   assign slot_next = CW'(rd_slot_ff) + CW'(1);
   assign last = rd_valid_ff && (slot_next == used_ff);

   // Smoothing: (3 * old + new) / 4, rounded toward zero.
   assign sum = {{2{old_rssi_ff[7]}}, old_rssi_ff} + {old_rssi_ff[7], old_rssi_ff, 1'b0} +
                {{2{sample_ff[7]}}, sample_ff};
   assign quot = sum[9] ? ((sum + 10'sd3) >>> 2) : (sum >>> 2);
   assign age = now_ff - old_seen_ff;
   assign ignored = has_zero_byte(id_ff) || (id_ff == own_id_ff);

   always_comb begin
      state_in = state_ff;
      used_in = used_ff;
      issue_in = issue_ff;
      rd_valid_in = 1'b0;
      found_in = found_ff;
      slot_in = slot_ff;
      old_rssi_in = old_rssi_ff;
      old_seen_in = old_seen_ff;
      load_rsp = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_rssi_in = rsp_rssi_ff;
      wr_en = 1'b0;
      wr_addr = slot_ff;
      wr_data = '{peer_id: id_ff, rssi: sample_ff, seen_ms: now_ff};

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               issue_in = '0;
               found_in = 1'b0;
               state_in = (used_ff == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               issue_in = issue_ff + CW'(1);
            end
            if (match) begin
               found_in = 1'b1;
               slot_in = rd_slot_ff;
               old_rssi_in = rd_data_ff.rssi;
               old_seen_in = rd_data_ff.seen_ms;
               state_in = ST_FINISH;
            end else if (last) begin
               state_in = ST_FINISH;
            end else begin
               rd_valid_in = issue;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
               rsp_rssi_in = UNKNOWN_RSSI;
               if (!mode_ff) begin
                  if (ignored) begin
                     rsp_status_in = STATUS_IGNORED;
                  end else if (found_ff) begin
                     wr_en = 1'b1;
                     wr_data.rssi = quot[7:0];
                     rsp_status_in = STATUS_UPDATED;
                     rsp_rssi_in = quot[7:0];
                  end else if (used_ff < ENTRIES_C) begin
                     wr_en = 1'b1;
                     wr_addr = used_ff[IW-1:0];
                     used_in = used_ff + CW'(1);
                     rsp_status_in = STATUS_INSERTED;
                     rsp_rssi_in = sample_ff;
                  end else begin
                     rsp_status_in = STATUS_FULL;
                  end
               end else begin
                  if (found_ff && (age < stale_limit_ff)) begin
                     rsp_status_in = STATUS_HIT;
                     rsp_rssi_in = old_rssi_ff;
                  end else begin
                     rsp_status_in = STATUS_MISS;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[issue_ff[IW-1:0]];
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         used_ff <= '0;
         rd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         own_id_ff <= OWN_ID_RESET;
         stale_limit_ff <= STALE_LIMIT_RESET;
      end else begin
         state_ff <= state_in;
         used_ff <= used_in;
         rd_valid_ff <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_OWN_ID:      own_id_ff <= csr_write_data;
               CSR_STALE_LIMIT: stale_limit_ff <= csr_write_data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_chan.mode;
         id_ff <= req_chan.peer_id;
         sample_ff <= req_chan.sample_rssi;
         now_ff <= req_chan.now_ms;
      end
      issue_ff <= issue_in;
      rd_slot_ff <= issue_ff[IW-1:0];
      found_ff <= found_in;
      slot_ff <= slot_in;
      old_rssi_ff <= old_rssi_in;
      old_seen_ff <= old_seen_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rssi_ff <= rsp_rssi_in;
   end

endmodule
